@@ hdl/rcia_pkg.sv @@
`timescale 1ns / 1ps
// Package for the reference-counted identifier allocator.
// Holds pool sizing constants, operation and status codes, and the item types.
// No dependencies.
package rcia_pkg;

    localparam int POOL_SIZE   = 256;
    localparam int COUNT_BITS  = 8;
    localparam int IDX_W       = $clog2(POOL_SIZE);
    localparam int CHUNK_W     = 16;
    localparam int NUM_CHUNKS  = POOL_SIZE / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
    localparam int POS_W       = $clog2(CHUNK_W);
    localparam int VISIT_W     = $clog2(NUM_CHUNKS + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ALLOC = 2'd0;
    localparam t_kind KIND_REF   = 2'd1;
    localparam t_kind KIND_UNREF = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EXHAUSTED = 2'd1;
    localparam t_status ST_NOT_HELD  = 2'd2;
    localparam t_status ST_OVERFLOW  = 2'd3;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] ident;
    } t_in_item;

    typedef struct packed {
        logic [31:0] granted_ident;
        t_status     status;
        logic        released;
    } t_out_item;

endpackage

@@ hdl/refcounted_id_allocator_core.sv @@
`timescale 1ns / 1ps
// Top level of the reference-counted identifier allocator.
// Depends on rcia_pkg.
//
// The block takes one transaction at a time and returns exactly one result
// for each. An add or drop reference passes from acceptance to a result in
// the output register through the synchronous read of the count memory,
// the modify and write back, and the load of the result. An allocate
// writes the new count, then searches for the next free identifier by
// scanning a held-bit map sixteen entries per cycle, wrapping once around
// the pool, and then loads the result. An allocate that finds the pool
// exhausted does not search. A result waiting in the output register does
// not block the start of the next transaction.
// There is no clearing pass after reset: held bits in flip-flops mark live
// counts.
module refcounted_id_allocator_core
    import rcia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RMW    = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [POOL_SIZE-1:0]   r_held, n_held;
    logic [IDX_W-1:0]       r_next_free, n_next_free;
    logic                   r_pool_full, n_pool_full;
    logic [31:0]            r_id_base, n_id_base;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;
    t_out_item              r_res, n_res;
    t_kind                  r_kind, n_kind;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_ok, n_ok;
    logic [CHUNK_IDX_W-1:0] r_chunk, n_chunk;
    logic [CHUNK_W-1:0]     r_mask, n_mask;
    logic [VISIT_W-1:0]     r_visits, n_visits;

    logic [COUNT_BITS-1:0]  r_mem [POOL_SIZE];
    logic [COUNT_BITS-1:0]  r_rd_data;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [COUNT_BITS-1:0]  mem_wdata;

    logic [31:0]            offset;
    logic [IDX_W-1:0]       in_idx;
    logic                   in_range;
    logic                   in_accept;
    logic [IDX_W-1:0]       start_idx;
    logic [CHUNK_W-1:0]     free_bits;
    logic [POS_W-1:0]       free_pos;
    logic                   free_found;

    assign offset     = i_in.ident - r_id_base;
    assign in_idx     = offset[IDX_W-1:0];
    assign in_range   = offset < 32'(POOL_SIZE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign start_idx  = r_next_free + IDX_W'(1);
    assign free_bits  = ~r_held[{r_chunk, {POS_W{1'b0}}} +: CHUNK_W] & r_mask;
    assign free_found = |free_bits;

    always_comb begin
        free_pos = '0;
        for (int k = CHUNK_W - 1; k >= 0; k--) begin
            if (free_bits[k]) begin
                free_pos = POS_W'(k);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_next_free = r_next_free;
        n_pool_full = r_pool_full;
        n_id_base   = i_cfg_we ? i_cfg_data : r_id_base;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_res       = r_res;
        n_kind      = r_kind;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_chunk     = r_chunk;
        n_mask      = r_mask;
        n_visits    = r_visits;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_kind = i_in.kind;
                    n_idx  = in_idx;
                    n_ok   = (i_in.kind == KIND_REF || i_in.kind == KIND_UNREF)
                             && in_range && r_held[in_idx];
                    n_res.granted_ident = i_in.ident;
                    n_res.status        = ST_NOT_HELD;
                    n_res.released      = 1'b0;
                    if (i_in.kind == KIND_ALLOC) begin
                        if (r_pool_full) begin
                            n_res.granted_ident = '0;
                            n_res.status        = ST_EXHAUSTED;
                            n_state             = S_DONE;
                        end else begin
                            mem_we              = 1'b1;
                            mem_waddr           = r_next_free;
                            mem_wdata           = COUNT_BITS'(1);
                            n_held[r_next_free] = 1'b1;
                            n_res.granted_ident = r_id_base + 32'(r_next_free);
                            n_res.status        = ST_OK;
                            n_chunk  = start_idx[IDX_W-1:POS_W];
                            n_mask   = {CHUNK_W{1'b1}} << start_idx[POS_W-1:0];
                            n_visits = '0;
                            n_state  = S_SEARCH;
                        end
                    end else begin
                        n_state = S_RMW;
                    end
                end
            end
            S_RMW: begin
                n_state = S_DONE;
                if (r_ok) begin
                    if (r_kind == KIND_REF) begin
                        if (r_rd_data == COUNT_MAX) begin
                            n_res.status = ST_OVERFLOW;
                        end else begin
                            mem_we       = 1'b1;
                            mem_wdata    = r_rd_data + COUNT_BITS'(1);
                            n_res.status = ST_OK;
                        end
                    end else begin
                        mem_we       = 1'b1;
                        mem_wdata    = r_rd_data - COUNT_BITS'(1);
                        n_res.status = ST_OK;
                        if (r_rd_data == COUNT_BITS'(1)) begin
                            n_held[r_idx]  = 1'b0;
                            n_res.released = 1'b1;
                            if (r_pool_full) begin
                                n_pool_full = 1'b0;
                                n_next_free = r_idx;
                            end
                        end
                    end
                end
            end
            S_SEARCH: begin
                if (free_found) begin
                    n_next_free = {r_chunk, free_pos};
                    n_state     = S_DONE;
                end else if (r_visits == VISIT_W'(NUM_CHUNKS)) begin
                    n_pool_full = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_chunk  = r_chunk + CHUNK_IDX_W'(1);
                    n_mask   = {CHUNK_W{1'b1}};
                    n_visits = r_visits + VISIT_W'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[in_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_next_free <= '0;
            r_pool_full <= 1'b0;
            r_id_base   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_next_free <= n_next_free;
            r_pool_full <= n_pool_full;
            r_id_base   <= n_id_base;
            r_out_valid <= n_out_valid;
        end
        r_out    <= n_out;
        r_res    <= n_res;
        r_kind   <= n_kind;
        r_idx    <= n_idx;
        r_ok     <= n_ok;
        r_chunk  <= n_chunk;
        r_mask   <= n_mask;
        r_visits <= n_visits;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ hdl/rcia_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the reference-counted identifier allocator.
// Depends on rcia_pkg and is bound to refcounted_id_allocator_core.
module rcia_checker
    import rcia_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("result or stall present right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken before the first finished");

    a_exhausted_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_EXHAUSTED
        |-> o_out.granted_ident == 32'd0 && !o_out.released)
        else $error("exhausted result carries an identifier or a release");

    a_release_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.released |-> o_out.status == ST_OK)
        else $error("release reported with a failing status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or dropped");

endmodule

bind refcounted_id_allocator_core rcia_checker u_rcia_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
